FILE: sv/tsri_pkg.sv
// Package for the timestamp-sorted insertion ring: beat types for both channels
// and the control word shared by the top level and the chain of cells.
// No dependencies.
`default_nettype none

package tsri_pkg;

	localparam int KEY_BITS     = 64;
	localparam int IN_PAY_BITS  = 32;
	localparam int FILL_OUT_BITS = 5;

	typedef logic [KEY_BITS-1:0] key_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]    sample_key;
		logic [IN_PAY_BITS-1:0] entry_payload;
	} in_item_t;

	typedef struct packed {
		logic                     is_newest;
		logic                     accepted;
		logic                     dropped_oldest;
		logic [FILL_OUT_BITS-1:0] fill_after;
	} out_item_t;

	// Broadcast to every cell in the cycle a beat is taken.
	typedef struct packed {
		logic shift_en;   // beat inserts (not rejected)
		logic drop;       // store full: shift towards the oldest end
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/tsri_cell.sv
// One position of the sorted chain: holds a key and payload, compares its key
// with the incoming one and takes the new entry or a neighbour's on insert.
// Depends on tsri_pkg.
`default_nettype none

module tsri_cell import tsri_pkg::*; #(
	parameter int PAY_W = 32
) (
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic             occupied,
	input  wire key_t             new_key,
	input  wire logic [PAY_W-1:0] new_pay,
	input  wire logic             le_prev,   // cell towards the oldest end
	input  wire key_t             key_prev,
	input  wire logic [PAY_W-1:0] pay_prev,
	input  wire logic             le_next,   // cell towards the newest end
	input  wire key_t             key_next,
	input  wire logic [PAY_W-1:0] pay_next,
	output logic                  le,
	output key_t                  key,
	output logic [PAY_W-1:0]      pay
);

	key_t             key_q;
	logic [PAY_W-1:0] pay_q;

	assign le  = occupied && (key_q <= new_key);
	assign key = key_q;
	assign pay = pay_q;

	// Stored keys ascend, so the le bits form a prefix; the boundary picks the slot.
	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			if (ctrl.drop) begin
				if (le && !le_next) begin
					key_q <= new_key;
					pay_q <= new_pay;
				end else if (le) begin
					key_q <= key_next;
					pay_q <= pay_next;
				end
			end else if (!le) begin
				if (le_prev) begin
					key_q <= new_key;
					pay_q <= new_pay;
				end else begin
					key_q <= key_prev;
					pay_q <= pay_prev;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/timestamp_sorted_ring_insert.sv
// Timestamp-sorted insertion buffer built as a row of compare-and-shift cells.
// Depends on tsri_pkg and tsri_cell.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) brings a 64-bit key and a
//   payload. Every cell compares its key with the new one in parallel; on the
//   same edge the cells past the insertion point move up one place (or, when
//   the store is full, those before it move down and the oldest falls out).
//   result channel (result_valid/result_ready/result) returns one beat per
//   sample beat: is_newest, accepted, dropped_oldest and fill_after.
//   The result is registered: result_valid rises in the cycle after sample
//   acceptance. Throughput is one beat per cycle while result_ready stays
//   high, set by the single compare-and-select across the cell row.
//   A beat is taken while the output register is empty or being emptied, so
//   a stalled receiver holds at most one result and then backpressures the
//   sample channel.
//   After reset the store is empty (fill zero) and no result is pending; the
//   cell contents are not cleared, only entries below the fill are ever used.
`default_nettype none

module timestamp_sorted_ring_insert import tsri_pkg::*; #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      sample_valid,
	output logic           sample_ready,
	input  wire in_item_t  sample,
	output logic           result_valid,
	input  wire logic      result_ready,
	output out_item_t      result
);

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic [FILL_W-1:0]       fill_q;
	logic                    result_valid_q;
	out_item_t               result_q;

	logic [QUEUE_DEPTH-1:0]  le;
	logic [QUEUE_DEPTH-1:0]  occupied;
	key_t                    cell_key [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_pay [QUEUE_DEPTH];
	logic [PAYLOAD_BITS+IN_PAY_BITS-1:0] pay_ext;
	logic [PAYLOAD_BITS-1:0] new_pay;
	logic                    take;
	logic                    full;
	logic                    reject;
	logic                    newest;
	logic [FILL_W-1:0]       fill_next;
	logic [FILL_W+FILL_OUT_BITS-1:0] fill_ext;
	cell_ctrl_t              ctrl;

	assign pay_ext = {{PAYLOAD_BITS{1'b0}}, sample.entry_payload};
	assign new_pay = pay_ext[PAYLOAD_BITS-1:0];

	assign sample_ready = !result_valid_q || result_ready;
	assign take         = sample_valid && sample_ready;
	assign full         = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign reject       = full && !le[0];
	assign newest       = &(le | ~occupied);
	assign fill_next    = full ? fill_q : fill_q + FILL_W'(1);
	assign fill_ext     = {{FILL_OUT_BITS{1'b0}}, fill_next};

	assign ctrl = '{shift_en: take && !reject, drop: full};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                    le_prev;
		logic                    le_next;
		key_t                    key_prev;
		key_t                    key_next;
		logic [PAYLOAD_BITS-1:0] pay_prev;
		logic [PAYLOAD_BITS-1:0] pay_next;

		assign occupied[i] = (fill_q > FILL_W'(i));

		if (i == 0) begin : g_first
			assign le_prev  = 1'b1;
			assign key_prev = sample.sample_key;
			assign pay_prev = new_pay;
		end else begin : g_mid_prev
			assign le_prev  = le[i-1];
			assign key_prev = cell_key[i-1];
			assign pay_prev = cell_pay[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign le_next  = 1'b0;
			assign key_next = sample.sample_key;
			assign pay_next = new_pay;
		end else begin : g_mid_next
			assign le_next  = le[i+1];
			assign key_next = cell_key[i+1];
			assign pay_next = cell_pay[i+1];
		end

		tsri_cell #(
			.PAY_W(PAYLOAD_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (occupied[i]),
			.new_key  (sample.sample_key),
			.new_pay  (new_pay),
			.le_prev  (le_prev),
			.key_prev (key_prev),
			.pay_prev (pay_prev),
			.le_next  (le_next),
			.key_next (key_next),
			.pay_next (pay_next),
			.le       (le[i]),
			.key      (cell_key[i]),
			.pay      (cell_pay[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (ctrl.shift_en) begin
				fill_q <= fill_next;
			end
			if (take) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result beat until the receiver takes it.
	always_ff @(posedge clk) begin
		if (take) begin
			result_q.is_newest      <= newest && !reject;
			result_q.accepted       <= !reject;
			result_q.dropped_oldest <= full && le[0];
			result_q.fill_after     <= reject ? fill_ext[FILL_OUT_BITS-1:0] &
			                           {FILL_OUT_BITS{1'b1}} :
			                           fill_ext[FILL_OUT_BITS-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
